// ===== rtl/pat_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the positional array table.
`default_nettype none

package pat_pkg;

    // Number of entries the table can hold.
    localparam int CAPACITY = 64;

    // Entry address width, count width (it must hold CAPACITY itself) and field widths.
    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int PW   = 7;
    localparam int VW   = 32;
    localparam int OW   = 7;
    localparam int CMPW = ((CW > PW) ? CW : PW) + 1;

    // Byte-padded widths of the packed stream data words.
    localparam int IN_DW  = ((PW + VW + 7) / 8) * 8;
    localparam int OUT_FW = 2 + 1 + OW + OW;
    localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;

    typedef enum logic [1:0] {
        K_UPDATE = 2'd0,
        K_INSERT = 2'd1,
        K_REMOVE = 2'd2,
        K_SEARCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INS,
        IDX_REM,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_VALUE
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        logic    rd_en;
        t_wr_op  wr_op;
        t_cnt_op cnt_op;
        logic    cmp;
        logic    res_load;
        t_status code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  upd_bad;
        logic  ins_bad;
        logic  full;
        logic  append;
        logic  rem_none;
        logic  ins_last;
        logic  rem_last;
        logic  srch_empty;
        logic  match;
        logic  out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/pat_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/pat_dp.sv =====
// Datapath: item registers, entry count, walk pointer, entry memory, compare and result register.
`default_nettype none

module pat_dp (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire pat_pkg::t_cmd           i_cmd,
    output pat_pkg::t_stat               o_stat,
    input  wire pat_pkg::t_kind          i_kind,
    input  wire logic [pat_pkg::PW-1:0]  i_pos,
    input  wire logic [pat_pkg::VW-1:0]  i_value,
    input  wire logic                    i_m_ready,
    output logic                         o_m_valid,
    output pat_pkg::t_status             o_status,
    output logic                         o_found,
    output logic [pat_pkg::OW-1:0]       o_found_pos,
    output logic [pat_pkg::OW-1:0]       o_entry_count
);
    import pat_pkg::*;

    t_kind                 r_kind;
    logic [PW-1:0]         r_pos;
    logic signed [VW-1:0]  r_value;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_addr;
    logic                  r_found;
    logic [CW-1:0]         r_fpos;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic                  r_out_found;
    logic [OW-1:0]         r_out_fpos;
    logic [OW-1:0]         r_out_cnt;

    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       cnt_x;
    logic [AW-1:0]         pos_m1;
    logic [AW-1:0]         cnt_m1;
    logic [VW-1:0]         rd_data;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [VW-1:0]         wdata;
    logic                  match;

    assign pos_x  = CMPW'(r_pos);
    assign cnt_x  = CMPW'(r_count);
    assign pos_m1 = AW'(r_pos - PW'(1));
    assign cnt_m1 = AW'(r_count - CW'(1));
    assign match  = r_rd_vld && (rd_data == r_value);

    always_comb begin
        o_stat            = '0;
        o_stat.kind       = r_kind;
        o_stat.upd_bad    = (pos_x == '0) || (pos_x > cnt_x);
        o_stat.ins_bad    = (pos_x == '0) || (pos_x > cnt_x + CMPW'(1));
        o_stat.full       = (cnt_x == CMPW'(CAPACITY));
        o_stat.append     = (pos_x == cnt_x + CMPW'(1));
        o_stat.rem_none   = (pos_x == cnt_x);
        o_stat.ins_last   = (r_idx == pos_m1);
        o_stat.rem_last   = (r_idx == cnt_m1);
        o_stat.srch_empty = (r_count == '0);
        o_stat.match      = match;
        o_stat.out_busy   = r_out_vld && !i_m_ready;
    end

    // Shift moves are one read behind: the entry read last cycle goes one slot up or down.
    always_comb begin
        we    = 1'b0;
        waddr = r_rd_addr;
        wdata = rd_data;
        case (i_cmd.wr_op)
            WR_UP: begin
                we    = r_rd_vld;
                waddr = r_rd_addr + AW'(1);
            end
            WR_DN: begin
                we    = r_rd_vld;
                waddr = r_rd_addr - AW'(1);
            end
            WR_VALUE: begin
                we    = 1'b1;
                waddr = pos_m1;
                wdata = r_value;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    pat_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            case (i_cmd.cnt_op)
                CNT_INC: r_count <= r_count + CW'(1);
                CNT_DEC: r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_ready) begin
                r_out_vld <= 1'b0;
            end
        end

        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_pos   <= i_pos;
            r_value <= i_value;
            r_found <= 1'b0;
            r_fpos  <= '0;
        end else if (i_cmd.cmp && match) begin
            r_found <= 1'b1;
            r_fpos  <= CW'(r_rd_addr) + CW'(1);
        end

        r_rd_addr <= r_idx;
        case (i_cmd.idx_op)
            IDX_INS:  r_idx <= cnt_m1;
            IDX_REM:  r_idx <= AW'(r_pos);
            IDX_ZERO: r_idx <= '0;
            IDX_DEC:  r_idx <= r_idx - AW'(1);
            IDX_INC:  r_idx <= r_idx + AW'(1);
            default:  r_idx <= r_idx;
        endcase

        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.code;
            r_out_found  <= r_found;
            r_out_fpos   <= OW'(r_fpos);
            r_out_cnt    <= OW'(r_count);
        end
    end

    assign o_m_valid     = r_out_vld;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_found_pos   = r_out_fpos;
    assign o_entry_count = r_out_cnt;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_count_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + CW'(1))
                      || (r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> !(r_out_vld && !i_m_ready))
        else $error("result register loaded while a stalled result waits");

endmodule

`default_nettype wire

// ===== rtl/pat_ctrl.sv =====
// Controller state machine that sequences update, insert, remove and search over the datapath.
`default_nettype none

module pat_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pat_pkg::t_stat i_stat,
    output pat_pkg::t_cmd       o_cmd
);
    import pat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_PUT,
        S_REM_SHIFT,
        S_REM_DRAIN,
        S_SRCH,
        S_SRCH_LAST,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_code;
    t_status n_code;
    t_cmd    cmd;

    always_comb begin
        n_state      = r_state;
        n_code       = r_code;
        cmd          = '0;
        cmd.idx_op   = IDX_HOLD;
        cmd.wr_op    = WR_NONE;
        cmd.cnt_op   = CNT_HOLD;
        cmd.code     = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_code  = ST_DONE;
                n_state = S_FINISH;
                case (i_stat.kind)
                    K_UPDATE: begin
                        if (i_stat.upd_bad) begin
                            n_code = ST_BADPOS;
                        end else begin
                            cmd.wr_op = WR_VALUE;
                        end
                    end
                    K_INSERT: begin
                        if (i_stat.ins_bad) begin
                            n_code = ST_BADPOS;
                        end else if (i_stat.full) begin
                            n_code = ST_FULL;
                        end else if (i_stat.append) begin
                            n_state = S_INS_PUT;
                        end else begin
                            cmd.idx_op = IDX_INS;
                            n_state    = S_INS_SHIFT;
                        end
                    end
                    K_REMOVE: begin
                        if (i_stat.upd_bad) begin
                            n_code = ST_BADPOS;
                        end else if (i_stat.rem_none) begin
                            cmd.cnt_op = CNT_DEC;
                        end else begin
                            cmd.idx_op = IDX_REM;
                            n_state    = S_REM_SHIFT;
                        end
                    end
                    default: begin
                        if (!i_stat.srch_empty) begin
                            cmd.idx_op = IDX_ZERO;
                            n_state    = S_SRCH;
                        end
                    end
                endcase
            end
            S_INS_SHIFT: begin
                cmd.rd_en = 1'b1;
                cmd.wr_op = WR_UP;
                if (i_stat.ins_last) begin
                    n_state = S_INS_DRAIN;
                end else begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_INS_DRAIN: begin
                cmd.wr_op = WR_UP;
                n_state   = S_INS_PUT;
            end
            S_INS_PUT: begin
                cmd.wr_op  = WR_VALUE;
                cmd.cnt_op = CNT_INC;
                n_state    = S_FINISH;
            end
            S_REM_SHIFT: begin
                cmd.rd_en = 1'b1;
                cmd.wr_op = WR_DN;
                if (i_stat.rem_last) begin
                    n_state = S_REM_DRAIN;
                end else begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_REM_DRAIN: begin
                cmd.wr_op  = WR_DN;
                cmd.cnt_op = CNT_DEC;
                n_state    = S_FINISH;
            end
            S_SRCH: begin
                cmd.cmp = 1'b1;
                if (i_stat.match) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.rd_en = 1'b1;
                    if (i_stat.rem_last) begin
                        n_state = S_SRCH_LAST;
                    end else begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            S_SRCH_LAST: begin
                cmd.cmp = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    cmd.res_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_accept_decode : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded on the next cycle");

    a_result_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after loading a result");

endmodule

`default_nettype wire

// ===== rtl/positional_array_table_unit.sv =====
// Top level of the positional array table: stream ports around the controller and datapath.
//
// The block keeps an ordered table of up to CAPACITY signed 32-bit entries and a count.
// Each item on the slave stream asks for an update, insert, remove or search; the kind
// travels on s_axis_tuser, the 1-based position and the value on s_axis_tdata. Every
// item gives exactly one item on the master stream with status, found flag, found
// position and the entry count after the operation.
// One item is worked on at a time. The controller returns to idle on the edge that
// raises m_axis_tvalid and can then take the next item. An update, a rejected item, a
// remove of the last entry or a search of an empty table goes from decode straight to
// the finish state, and an insert at the end passes through the put state first. Insert
// and remove move entries through the entry memory one per cycle, then write the last
// entry read; an insert then writes the new value. A search reads one entry per cycle
// and stops at the first match, or after the last entry in use when nothing matches.
// Results sit in an output register: the block accepts the next item while a result
// still waits, and only holds a finished item back if the receiver is stalling.
// Reset clears the count and the handshake state at once. The entry memory is not
// cleared: entries at or above the count are never read before they are written, so
// no clearing pass is needed and the block is ready as soon as reset is released.
`default_nettype none

module positional_array_table_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: position (7), value (32), zero padding.
    input  wire logic [pat_pkg::IN_DW-1:0]   s_axis_tdata,
    // Fields from bit 0 up: kind (2).
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // Fields from bit 0 up: status (2), found (1), found_position (7),
    // entry_count (7), zero padding.
    output logic [pat_pkg::OUT_DW-1:0]       m_axis_tdata
);
    import pat_pkg::*;

    t_cmd          cmd;
    t_stat         stat;
    t_kind         in_kind;
    t_status       out_status;
    logic          out_found;
    logic [OW-1:0] out_fpos;
    logic [OW-1:0] out_cnt;

    assign in_kind = t_kind'(s_axis_tuser);

    pat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pat_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (in_kind),
        .i_pos         (s_axis_tdata[PW-1:0]),
        .i_value       (s_axis_tdata[PW+VW-1:PW]),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_status      (out_status),
        .o_found       (out_found),
        .o_found_pos   (out_fpos),
        .o_entry_count (out_cnt)
    );

    assign m_axis_tdata = OUT_DW'({out_cnt, out_fpos, out_found, out_status});

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking stream testbench for the positional array table: directed and random operations.
module tb;
    import pat_pkg::*;

    // One operation offered on the slave stream.
    typedef struct {
        t_kind              kind;
        logic [PW-1:0]      pos;
        logic signed [31:0] value;
    } op_t;

    // One result expected on the master stream.
    typedef struct {
        t_status       status;
        logic          found;
        logic [OW-1:0] found_pos;
        logic [OW-1:0] entry_count;
    } res_t;

    // Mix of operations used for one stretch of random stimulus.
    typedef enum int {
        MIX_GROW,
        MIX_EVEN,
        MIX_SHRINK
    } mix_e;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AT        = 1200;
    localparam int HOLD_LEN       = 300;
    localparam int ITEMS_PER_PHASE = 510;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DW-1:0]     s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]    m_axis_tdata;

    positional_array_table_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    op_t         op_queue[$];
    res_t        result_queue[$];
    op_t         offered_op;
    int          n_issued     = 0;
    int          n_in_taken   = 0;
    int          n_results    = 0;
    int          n_errors     = 0;
    int          quiet_cycles = 0;
    int          snd_idle     = 14;
    int          rcv_idle     = 67;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;

    // Shadow copy of the table, advanced as each item is accepted.
    logic signed [31:0] table_mem[CAPACITY];
    int                 table_count = 0;

    // Entry count as seen by the stimulus generator, to aim positions at valid ranges.
    int                 gen_count = 0;

    initial begin
        for (int i = 0; i < CAPACITY; i++) table_mem[i] = '0;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", n_results, msg);
        n_errors++;
    endtask

    function automatic res_t table_apply(op_t op);
        res_t r;
        int   p;
        r.status    = ST_DONE;
        r.found     = 1'b0;
        r.found_pos = '0;
        p           = op.pos;
        case (op.kind)
            K_UPDATE: begin
                if (p < 1 || p > table_count) r.status = ST_BADPOS;
                else table_mem[p-1] = op.value;
            end
            K_INSERT: begin
                // The position test wins over the full test.
                if (p < 1 || p > table_count + 1) begin
                    r.status = ST_BADPOS;
                end else if (table_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = table_count; i > p - 1; i--) table_mem[i] = table_mem[i-1];
                    table_mem[p-1] = op.value;
                    table_count++;
                end
            end
            K_REMOVE: begin
                if (p < 1 || p > table_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = p - 1; i + 1 < table_count; i++) table_mem[i] = table_mem[i+1];
                    table_count--;
                    table_mem[table_count] = '0;
                end
            end
            default: begin
                // Only entries in use are searched, and the first match is reported.
                for (int i = 0; i < table_count; i++) begin
                    if (!r.found && table_mem[i] == op.value) begin
                        r.found     = 1'b1;
                        r.found_pos = 7'(i + 1);
                    end
                end
            end
        endcase
        r.entry_count = 7'(table_count);
        return r;
    endfunction

    task automatic queue_op(t_kind k, int pos, logic [31:0] val);
        op_t op;
        op.kind  = k;
        op.pos   = pos[PW-1:0];
        op.value = val;
        op_queue.push_back(op);
        if (k == K_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < CAPACITY)
            gen_count++;
        else if (k == K_REMOVE && pos >= 1 && pos <= gen_count)
            gen_count--;
    endtask

    task automatic queue_random(int n_items);
        mix_e        mix;
        int          seg_left;
        int          r;
        int          hi;
        int          pos;
        t_kind       k;
        logic [31:0] val;
        // Each phase opens by growing the table, so that the full case is reached.
        mix      = MIX_GROW;
        seg_left = 160;
        for (int n = 0; n < n_items; n++) begin
            if (seg_left == 0) begin
                r        = $urandom_range(2);
                mix      = (r == 0) ? MIX_GROW : (r == 1) ? MIX_EVEN : MIX_SHRINK;
                seg_left = $urandom_range(150, 60);
            end
            seg_left--;
            r = $urandom_range(99);
            case (mix)
                MIX_GROW:   k = (r < 60) ? K_INSERT : (r < 72) ? K_UPDATE :
                                (r < 82) ? K_REMOVE : K_SEARCH;
                MIX_EVEN:   k = (r < 30) ? K_INSERT : (r < 50) ? K_UPDATE :
                                (r < 75) ? K_REMOVE : K_SEARCH;
                default:    k = (r < 10) ? K_INSERT : (r < 25) ? K_UPDATE :
                                (r < 75) ? K_REMOVE : K_SEARCH;
            endcase
            hi = (k == K_INSERT) ? gen_count + 1 : gen_count;
            r  = $urandom_range(99);
            if (k == K_SEARCH || r < 10 || hi == 0) pos = $urandom_range(127);
            else if (r < 20) pos = hi;
            else if (r < 25) pos = 1;
            else pos = $urandom_range(hi, 1);
            // A small pool of keys gives duplicates and search hits.
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(7))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7fff_ffff;
                    2:       val = 32'h0000_0000;
                    3:       val = 32'hffff_ffff;
                    default: val = 32'($urandom_range(4, 1));
                endcase
            end else begin
                val = $urandom;
            end
            queue_op(k, pos, val);
        end
    endtask

    // Sender: offers the next pending item, holding it until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && n_in_taken != n_issued)) begin
            if (op_queue.size() != 0 && $urandom_range(99) >= snd_idle) begin
                offered_op    <= op_queue[0];
                s_axis_tdata  <= IN_DW'({op_queue[0].value, op_queue[0].pos});
                s_axis_tuser  <= op_queue[0].kind;
                s_axis_tvalid <= 1'b1;
                n_issued      <= n_issued + 1;
                void'(op_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted item advances the shadow table and queues its expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            result_queue.push_back(table_apply(offered_op));
            n_in_taken <= n_in_taken + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && n_in_taken >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin : check_result
        res_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_queue.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
            end else begin
                want = result_queue.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              m_axis_tdata[1:0], want.status));
                if (m_axis_tdata[2] !== want.found)
                    report_mismatch($sformatf("found got %0d, expected %0d",
                                              m_axis_tdata[2], want.found));
                if (m_axis_tdata[9:3] !== want.found_pos)
                    report_mismatch($sformatf("found_position got %0d, expected %0d",
                                              m_axis_tdata[9:3], want.found_pos));
                if (m_axis_tdata[16:10] !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                              m_axis_tdata[16:10], want.entry_count));
            end
            n_results <= n_results + 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        // Directed part: empty table, ends of every range, duplicates and ignored fields.
        queue_op(K_SEARCH, 0, 32'h0000_0000);
        queue_op(K_UPDATE, 1, 32'h1234_5678);
        queue_op(K_REMOVE, 1, 32'h0000_0000);
        queue_op(K_INSERT, 0, 32'h0000_0005);
        queue_op(K_INSERT, 2, 32'h0000_0005);
        queue_op(K_INSERT, 1, 32'h8000_0000);
        queue_op(K_INSERT, 2, 32'h7fff_ffff);
        queue_op(K_INSERT, 1, 32'h0000_0000);
        queue_op(K_INSERT, 127, 32'hffff_ffff);
        queue_op(K_UPDATE, 3, 32'hffff_ffff);
        queue_op(K_UPDATE, 4, 32'h0000_0001);
        queue_op(K_UPDATE, 0, 32'h0000_0001);
        queue_op(K_INSERT, 2, 32'hffff_ffff);
        queue_op(K_SEARCH, 0, 32'hffff_ffff);
        queue_op(K_SEARCH, 0, 32'h7fff_ffff);
        queue_op(K_SEARCH, 0, 32'h0000_0000);
        queue_op(K_REMOVE, 5, 32'h0000_0000);
        queue_op(K_REMOVE, 0, 32'h0000_0000);
        queue_op(K_REMOVE, 4, 32'h0000_0000);
        queue_op(K_SEARCH, 0, 32'hffff_ffff);
        queue_op(K_REMOVE, 1, 32'h0000_0000);
        queue_op(K_SEARCH, 127, 32'h8000_0000);
        queue_op(K_UPDATE, 127, 32'h0000_0002);
        queue_random(ITEMS_PER_PHASE);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            if (phase != 0) queue_random(ITEMS_PER_PHASE);
            // The sender pauses here until every expected result has come back.
            while (op_queue.size() != 0 || n_in_taken != n_issued || result_queue.size() != 0)
                @(posedge i_clk);
            snd_idle = (phase == 0) ? 67 : 0;
            rcv_idle = (phase == 0) ? 14 : 0;
        end

        repeat (100) @(posedge i_clk);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
